// File: src/rrts_pkg.sv
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

	localparam int NUM_TASKS = 64;
	localparam int ID_W      = 7;
	localparam int SLOT_W    = $clog2(NUM_TASKS);
	localparam int GRP       = 8;
	localparam int GRP_W     = $clog2(GRP);
	localparam int NUM_GRP   = NUM_TASKS / GRP;
	localparam int REFS_W    = 7;
	localparam int QLEN_W    = 16;
	localparam int REASON_W  = 8;

	localparam logic [ID_W-1:0]   IDLE_ID   = 7'd0;
	localparam logic [ID_W-1:0]   PROT_ID   = 7'd1;
	localparam logic [ID_W-1:0]   MAX_ID    = ID_W'(NUM_TASKS);
	localparam logic [REFS_W-1:0] REFS_MAX  = 7'd127;
	localparam logic [QLEN_W-1:0] QLEN_RST  = 16'd20;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_BLOCK   = 3'd1,
		OP_RESUME  = 3'd2,
		OP_SWITCH  = 3'd3,
		OP_DESTROY = 3'd4,
		OP_EXIT    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK   = 3'd0,
		STAT_FULL = 3'd1,
		STAT_PROT = 3'd2,
		STAT_REFD = 3'd3,
		STAT_BAD  = 3'd4
	} stat_t;

	// Micro-operation that the datapath performs in the current cycle
	typedef enum logic [3:0] {
		MOP_IDLE,
		MOP_READ,
		MOP_CHECK,
		MOP_CR_A,
		MOP_CR_B,
		MOP_BLK,
		MOP_RES,
		MOP_DS_A,
		MOP_DS_B,
		MOP_EX,
		MOP_SW_RD,
		MOP_SW_UL,
		MOP_SW_PU,
		MOP_DONE
	} mop_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_CR_A,
		S_CR_B,
		S_BLK,
		S_RES,
		S_DS_A,
		S_DS_B,
		S_EX,
		S_SW_RD,
		S_SW_UL,
		S_SW_PU,
		S_DONE
	} state_t;

	typedef struct packed {
		mop_t mop;
		logic load;
		logic emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic fail;
	} sts_t;

endpackage

// File: src/rrts_ctrl.sv
// Controller state machine that sequences one scheduler item through the datapath.
module rrts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  rrts_pkg::sts_t  sts,
	output rrts_pkg::cmd_t  cmd
);

	rrts_pkg::state_t state_q, state_nxt;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !(out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rrts_pkg::S_IDLE: begin
				if (in_valid) state_nxt = rrts_pkg::S_READ;
			end
			rrts_pkg::S_READ: state_nxt = rrts_pkg::S_CHECK;
			rrts_pkg::S_CHECK: begin
				if (sts.fail) begin
					state_nxt = rrts_pkg::S_DONE;
				end else begin
					unique case (sts.op)
						rrts_pkg::OP_CREATE:  state_nxt = rrts_pkg::S_CR_A;
						rrts_pkg::OP_BLOCK:   state_nxt = rrts_pkg::S_BLK;
						rrts_pkg::OP_RESUME:  state_nxt = rrts_pkg::S_RES;
						rrts_pkg::OP_SWITCH:  state_nxt = rrts_pkg::S_SW_RD;
						rrts_pkg::OP_DESTROY: state_nxt = rrts_pkg::S_DS_A;
						rrts_pkg::OP_EXIT:    state_nxt = rrts_pkg::S_EX;
						default:              state_nxt = rrts_pkg::S_DONE;
					endcase
				end
			end
			rrts_pkg::S_CR_A:  state_nxt = rrts_pkg::S_CR_B;
			rrts_pkg::S_CR_B:  state_nxt = rrts_pkg::S_DONE;
			rrts_pkg::S_BLK:   state_nxt = rrts_pkg::S_DONE;
			rrts_pkg::S_RES:   state_nxt = rrts_pkg::S_DONE;
			rrts_pkg::S_DS_A:  state_nxt = rrts_pkg::S_DS_B;
			rrts_pkg::S_DS_B:  state_nxt = rrts_pkg::S_DONE;
			rrts_pkg::S_EX:    state_nxt = rrts_pkg::S_SW_RD;
			rrts_pkg::S_SW_RD: state_nxt = rrts_pkg::S_SW_UL;
			rrts_pkg::S_SW_UL: state_nxt = rrts_pkg::S_SW_PU;
			rrts_pkg::S_SW_PU: state_nxt = rrts_pkg::S_DONE;
			rrts_pkg::S_DONE: begin
				if (out_free) state_nxt = rrts_pkg::S_IDLE;
			end
			default: state_nxt = rrts_pkg::S_IDLE;
		endcase
	end

	// Drive commands
	always_comb begin
		in_stall = (state_q != rrts_pkg::S_IDLE);
		cmd.load = (state_q == rrts_pkg::S_IDLE) && in_valid;
		cmd.emit = (state_q == rrts_pkg::S_DONE) && out_free;
		unique case (state_q)
			rrts_pkg::S_IDLE:  cmd.mop = rrts_pkg::MOP_IDLE;
			rrts_pkg::S_READ:  cmd.mop = rrts_pkg::MOP_READ;
			rrts_pkg::S_CHECK: cmd.mop = rrts_pkg::MOP_CHECK;
			rrts_pkg::S_CR_A:  cmd.mop = rrts_pkg::MOP_CR_A;
			rrts_pkg::S_CR_B:  cmd.mop = rrts_pkg::MOP_CR_B;
			rrts_pkg::S_BLK:   cmd.mop = rrts_pkg::MOP_BLK;
			rrts_pkg::S_RES:   cmd.mop = rrts_pkg::MOP_RES;
			rrts_pkg::S_DS_A:  cmd.mop = rrts_pkg::MOP_DS_A;
			rrts_pkg::S_DS_B:  cmd.mop = rrts_pkg::MOP_DS_B;
			rrts_pkg::S_EX:    cmd.mop = rrts_pkg::MOP_EX;
			rrts_pkg::S_SW_RD: cmd.mop = rrts_pkg::MOP_SW_RD;
			rrts_pkg::S_SW_UL: cmd.mop = rrts_pkg::MOP_SW_UL;
			rrts_pkg::S_SW_PU: cmd.mop = rrts_pkg::MOP_SW_PU;
			rrts_pkg::S_DONE:  cmd.mop = rrts_pkg::MOP_DONE;
			default:           cmd.mop = rrts_pkg::MOP_IDLE;
		endcase
	end

endmodule

// File: src/rrts_datapath.sv
// Datapath of the scheduler: task tables, run queue links, free-slot search and result register.
module rrts_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrts_pkg::cmd_t                cmd,
	output rrts_pkg::sts_t                sts,
	input  logic                          quantum_length_wr_en,
	input  logic [rrts_pkg::QLEN_W-1:0]   quantum_length_wr_data,
	input  logic [2:0]                    opcode,
	input  logic [rrts_pkg::ID_W-1:0]     target_task,
	input  logic [rrts_pkg::ID_W-1:0]     pager_id,
	input  logic [rrts_pkg::REASON_W-1:0] exit_reason,
	output logic [2:0]                    status,
	output logic [rrts_pkg::ID_W-1:0]     created_task,
	output logic [rrts_pkg::ID_W-1:0]     running_task,
	output logic [rrts_pkg::QLEN_W-1:0]   quantum_reload,
	output logic                          notify_valid,
	output logic [rrts_pkg::ID_W-1:0]     notify_pager,
	output logic [rrts_pkg::REASON_W-1:0] notify_reason
);

	localparam int N  = rrts_pkg::NUM_TASKS;
	localparam int IW = rrts_pkg::ID_W;
	localparam int SW = rrts_pkg::SLOT_W;
	localparam int RW = rrts_pkg::REFS_W;

	function automatic logic in_range(input logic [IW-1:0] id);
		in_range = (id != rrts_pkg::IDLE_ID) && (id <= rrts_pkg::MAX_ID);
	endfunction

	function automatic logic [SW-1:0] slot(input logic [IW-1:0] id);
		slot = SW'(id - IW'(1));
	endfunction

	// Captured item
	rrts_pkg::op_t                op_q;
	logic [IW-1:0]                tgt_q, pg_q;
	logic [rrts_pkg::REASON_W-1:0] reason_q;

	// Control state
	logic [N-1:0]                 used_q, linked_q;
	logic [IW-1:0]                head_q, tail_q, cur_q;
	logic [rrts_pkg::QLEN_W-1:0]  qlen_q;

	// Table memories
	logic                         run_mem   [N];
	logic [IW-1:0]                pager_mem [N];
	logic [RW-1:0]                refs_mem  [N];
	logic [IW-1:0]                next_mem  [N];
	logic [IW-1:0]                prev_mem  [N];
	logic                         rd_run_q;
	logic [IW-1:0]                rd_pager_q, rd_next_q, rd_prev_q;
	logic [RW-1:0]                rd_refs_q;

	// Free-slot search tree
	logic                         grp_any [rrts_pkg::NUM_GRP];
	logic [rrts_pkg::GRP_W-1:0]   grp_low [rrts_pkg::NUM_GRP];
	logic                         grp_any_s1 [rrts_pkg::NUM_GRP];
	logic [rrts_pkg::GRP_W-1:0]   grp_low_s1 [rrts_pkg::NUM_GRP];
	logic                         tree_any;
	logic [IW-1:0]                tree_tid;

	// Working registers
	rrts_pkg::stat_t              stat_q;
	logic [IW-1:0]                tid_q, pgv_q, created_q, swnext_q;
	logic                         swpush_q;
	logic [rrts_pkg::QLEN_W-1:0]  quantum_q;
	logic                         nvalid_q;
	logic [IW-1:0]                npager_q;
	logic [rrts_pkg::REASON_W-1:0] nreason_q;

	// Result register
	rrts_pkg::stat_t              out_status_q;
	logic [IW-1:0]                out_created_q, out_running_q, out_npager_q;
	logic [rrts_pkg::QLEN_W-1:0]  out_quantum_q;
	logic                         out_nvalid_q;
	logic [rrts_pkg::REASON_W-1:0] out_nreason_q;

	// Combinational
	logic [IW-1:0]                obj;
	logic                         obj_live, cur_run;
	rrts_pkg::stat_t              chk_stat;
	logic                         en_run, en_pager, en_refs, en_next, en_prev;
	logic [SW-1:0]                ra_run, ra_pager, ra_refs, ra_next, ra_prev;
	logic                         ul_en, pu_en;
	logic [IW-1:0]                ul_t, ul_p, ul_n, pu_t;
	logic                         run_we, pager_we, refs_we, next_we, prev_we;
	logic [SW-1:0]                run_wa, pager_wa, refs_wa, next_wa, prev_wa;
	logic                         run_wd;
	logic [IW-1:0]                pager_wd, next_wd, prev_wd;
	logic [RW-1:0]                refs_wd;
	logic [IW-1:0]                sw_next;

	assign obj      = (op_q == rrts_pkg::OP_EXIT) ? cur_q : tgt_q;
	assign obj_live = in_range(obj) && used_q[slot(obj)];
	assign cur_run  = (cur_q != rrts_pkg::IDLE_ID) && used_q[slot(cur_q)] && rd_run_q;
	assign sw_next  = (head_q != rrts_pkg::IDLE_ID) ? head_q :
	                  (cur_run ? cur_q : rrts_pkg::IDLE_ID);

	// Report the decoded item to the controller
	assign sts.op   = op_q;
	assign sts.fail = (chk_stat != rrts_pkg::STAT_OK);

	// Capture the item and the quantum register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= rrts_pkg::op_t'(opcode);
			tgt_q    <= target_task;
			pg_q     <= pager_id;
			reason_q <= exit_reason;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q <= rrts_pkg::QLEN_RST;
		end else if (quantum_length_wr_en) begin
			qlen_q <= quantum_length_wr_data;
		end
	end

	// Select read addresses per step
	always_comb begin
		en_run   = 1'b0;
		en_pager = 1'b0;
		en_refs  = 1'b0;
		en_next  = 1'b0;
		en_prev  = 1'b0;
		ra_run   = slot(obj);
		ra_pager = slot(obj);
		ra_next  = slot(obj);
		ra_prev  = slot(obj);
		ra_refs  = (op_q == rrts_pkg::OP_CREATE) ? slot(pg_q) : slot(obj);
		case (cmd.mop)
			rrts_pkg::MOP_READ: begin
				en_run   = 1'b1;
				en_pager = 1'b1;
				en_refs  = 1'b1;
				en_next  = 1'b1;
				en_prev  = 1'b1;
			end
			rrts_pkg::MOP_DS_A: begin
				en_refs = 1'b1;
				ra_refs = slot(rd_pager_q);
			end
			rrts_pkg::MOP_SW_RD: begin
				en_next = 1'b1;
				ra_next = slot(head_q);
				en_run  = 1'b1;
				ra_run  = slot(cur_q);
			end
			default: ;
		endcase
	end

	// Validate the item
	always_comb begin
		case (op_q)
			rrts_pkg::OP_CREATE:
				chk_stat = tree_any ? rrts_pkg::STAT_OK : rrts_pkg::STAT_FULL;
			rrts_pkg::OP_BLOCK:
				chk_stat = (obj_live && rd_run_q) ? rrts_pkg::STAT_OK : rrts_pkg::STAT_BAD;
			rrts_pkg::OP_RESUME:
				chk_stat = (obj_live && !rd_run_q) ? rrts_pkg::STAT_OK : rrts_pkg::STAT_BAD;
			rrts_pkg::OP_SWITCH:
				chk_stat = rrts_pkg::STAT_OK;
			rrts_pkg::OP_DESTROY: begin
				if (!obj_live || tgt_q == cur_q)        chk_stat = rrts_pkg::STAT_BAD;
				else if (tgt_q == rrts_pkg::PROT_ID)   chk_stat = rrts_pkg::STAT_PROT;
				else if (rd_refs_q != '0)              chk_stat = rrts_pkg::STAT_REFD;
				else                                   chk_stat = rrts_pkg::STAT_OK;
			end
			rrts_pkg::OP_EXIT:
				chk_stat = obj_live ? rrts_pkg::STAT_OK : rrts_pkg::STAT_BAD;
			default:
				chk_stat = rrts_pkg::STAT_BAD;
		endcase
	end

	// Find the lowest free slot inside each group
	always_comb begin
		for (int g = 0; g < rrts_pkg::NUM_GRP; g++) begin
			grp_any[g] = 1'b0;
			grp_low[g] = '0;
			for (int b = rrts_pkg::GRP - 1; b >= 0; b--) begin
				if (!used_q[g*rrts_pkg::GRP + b]) begin
					grp_any[g] = 1'b1;
					grp_low[g] = rrts_pkg::GRP_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mop == rrts_pkg::MOP_READ) begin
			for (int g = 0; g < rrts_pkg::NUM_GRP; g++) begin
				grp_any_s1[g] <= grp_any[g];
				grp_low_s1[g] <= grp_low[g];
			end
		end
	end

	// Pick the first group with a free slot
	always_comb begin
		tree_any = 1'b0;
		tree_tid = '0;
		for (int g = rrts_pkg::NUM_GRP - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				tree_any = 1'b1;
				tree_tid = IW'({(SW - rrts_pkg::GRP_W)'(g), grp_low_s1[g]}) + IW'(1);
			end
		end
	end

	// Queue link and push requests
	always_comb begin
		ul_en = 1'b0;
		ul_t  = obj;
		ul_p  = (obj == head_q) ? rrts_pkg::IDLE_ID : rd_prev_q;
		ul_n  = (obj == tail_q) ? rrts_pkg::IDLE_ID : rd_next_q;
		pu_en = 1'b0;
		pu_t  = obj;
		case (cmd.mop)
			rrts_pkg::MOP_BLK,
			rrts_pkg::MOP_DS_A,
			rrts_pkg::MOP_EX:    ul_en = linked_q[slot(obj)];
			rrts_pkg::MOP_RES:   pu_en = !linked_q[slot(obj)];
			rrts_pkg::MOP_CR_B: begin
				pu_en = 1'b1;
				pu_t  = tid_q;
			end
			rrts_pkg::MOP_SW_UL: begin
				ul_en = (head_q != rrts_pkg::IDLE_ID);
				ul_t  = head_q;
				ul_p  = rrts_pkg::IDLE_ID;
				ul_n  = (head_q == tail_q) ? rrts_pkg::IDLE_ID : rd_next_q;
			end
			rrts_pkg::MOP_SW_PU: begin
				pu_en = swpush_q;
				pu_t  = cur_q;
			end
			default: ;
		endcase
	end

	// Memory write ports
	always_comb begin
		next_we  = 1'b0;
		next_wa  = slot(ul_p);
		next_wd  = ul_n;
		prev_we  = 1'b0;
		prev_wa  = slot(ul_n);
		prev_wd  = ul_p;
		if (ul_en) begin
			next_we = (ul_p != rrts_pkg::IDLE_ID);
			prev_we = (ul_n != rrts_pkg::IDLE_ID);
		end else if (pu_en) begin
			next_we = (tail_q != rrts_pkg::IDLE_ID);
			next_wa = slot(tail_q);
			next_wd = pu_t;
			prev_we = 1'b1;
			prev_wa = slot(pu_t);
			prev_wd = tail_q;
		end

		run_we   = 1'b0;
		run_wa   = slot(obj);
		run_wd   = 1'b0;
		pager_we = 1'b0;
		pager_wa = slot(tid_q);
		pager_wd = pgv_q;
		refs_we  = 1'b0;
		refs_wa  = slot(tid_q);
		refs_wd  = '0;
		case (cmd.mop)
			rrts_pkg::MOP_CR_A: begin
				run_we   = 1'b1;
				run_wa   = slot(tid_q);
				run_wd   = 1'b1;
				pager_we = 1'b1;
				refs_we  = 1'b1;
			end
			rrts_pkg::MOP_CR_B: begin
				refs_we = (pgv_q != rrts_pkg::IDLE_ID) && (rd_refs_q != rrts_pkg::REFS_MAX);
				refs_wa = slot(pgv_q);
				refs_wd = rd_refs_q + RW'(1);
			end
			rrts_pkg::MOP_BLK,
			rrts_pkg::MOP_EX:    run_we = 1'b1;
			rrts_pkg::MOP_RES: begin
				run_we = 1'b1;
				run_wd = 1'b1;
			end
			rrts_pkg::MOP_DS_B: begin
				refs_we = (rd_pager_q != rrts_pkg::IDLE_ID) && (rd_refs_q != '0);
				refs_wa = slot(rd_pager_q);
				refs_wd = rd_refs_q - RW'(1);
			end
			default: ;
		endcase
	end

	// Write and read the table memories
	always_ff @(posedge clk) begin
		if (run_we)   run_mem[run_wa]     <= run_wd;
		if (pager_we) pager_mem[pager_wa] <= pager_wd;
		if (refs_we)  refs_mem[refs_wa]   <= refs_wd;
		if (next_we)  next_mem[next_wa]   <= next_wd;
		if (prev_we)  prev_mem[prev_wa]   <= prev_wd;
		if (en_run)   rd_run_q   <= run_mem[ra_run];
		if (en_pager) rd_pager_q <= pager_mem[ra_pager];
		if (en_refs)  rd_refs_q  <= refs_mem[ra_refs];
		if (en_next)  rd_next_q  <= next_mem[ra_next];
		if (en_prev)  rd_prev_q  <= prev_mem[ra_prev];
	end

	// Update slot flags, queue ends and the running task
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			linked_q <= '0;
			head_q   <= rrts_pkg::IDLE_ID;
			tail_q   <= rrts_pkg::IDLE_ID;
			cur_q    <= rrts_pkg::IDLE_ID;
		end else begin
			if (ul_en) begin
				if (ul_p == rrts_pkg::IDLE_ID) head_q <= ul_n;
				if (ul_n == rrts_pkg::IDLE_ID) tail_q <= ul_p;
				linked_q[slot(ul_t)] <= 1'b0;
			end else if (pu_en) begin
				if (tail_q == rrts_pkg::IDLE_ID) head_q <= pu_t;
				tail_q <= pu_t;
				linked_q[slot(pu_t)] <= 1'b1;
			end
			if (cmd.mop == rrts_pkg::MOP_CR_A) used_q[slot(tid_q)] <= 1'b1;
			if (cmd.mop == rrts_pkg::MOP_DS_A) used_q[slot(obj)]   <= 1'b0;
			if (cmd.mop == rrts_pkg::MOP_SW_PU) cur_q <= swnext_q;
		end
	end

	// Working registers for the current item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quantum_q <= '0;
			nvalid_q  <= 1'b0;
			npager_q  <= rrts_pkg::IDLE_ID;
			nreason_q <= '0;
		end
		if (cmd.mop == rrts_pkg::MOP_CHECK) begin
			stat_q    <= chk_stat;
			tid_q     <= tree_tid;
			pgv_q     <= (in_range(pg_q) && used_q[slot(pg_q)]) ? pg_q : rrts_pkg::IDLE_ID;
			created_q <= (op_q == rrts_pkg::OP_CREATE && tree_any) ? tree_tid
			                                                        : rrts_pkg::IDLE_ID;
		end
		if (cmd.mop == rrts_pkg::MOP_EX && rd_pager_q != rrts_pkg::IDLE_ID) begin
			nvalid_q  <= 1'b1;
			npager_q  <= rd_pager_q;
			nreason_q <= reason_q;
		end
		// Re-queue the previous task only when it is not already queued
		if (cmd.mop == rrts_pkg::MOP_SW_UL) begin
			swnext_q  <= sw_next;
			swpush_q  <= (sw_next != cur_q) && cur_run && !linked_q[slot(cur_q)];
			quantum_q <= (sw_next != rrts_pkg::IDLE_ID) ? qlen_q : '0;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q  <= stat_q;
			out_created_q <= created_q;
			out_running_q <= cur_q;
			out_quantum_q <= quantum_q;
			out_nvalid_q  <= nvalid_q;
			out_npager_q  <= npager_q;
			out_nreason_q <= nreason_q;
		end
	end

	assign status         = out_status_q;
	assign created_task   = out_created_q;
	assign running_task   = out_running_q;
	assign quantum_reload = out_quantum_q;
	assign notify_valid   = out_nvalid_q;
	assign notify_pager   = out_npager_q;
	assign notify_reason  = out_nreason_q;

endmodule

// File: src/round_robin_task_scheduler_core.sv
// Each item steps through READ, CHECK and the states of its operation to DONE; bad items
// go from CHECK straight to DONE, and exit runs EX before the switch states. One item is
// in flight at a time; the table memories' single ports set the steps.
// A finished result sits in an output register, and the next item is accepted meanwhile.
// Reset (arst_n low) empties the task table and run queue, makes idle the running task
// and sets the quantum to 20; no clearing pass is needed.
module round_robin_task_scheduler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          quantum_length_wr_en,
	input  logic [rrts_pkg::QLEN_W-1:0]   quantum_length_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic [rrts_pkg::ID_W-1:0]     target_task,
	input  logic [rrts_pkg::ID_W-1:0]     pager_id,
	input  logic [rrts_pkg::REASON_W-1:0] exit_reason,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [rrts_pkg::ID_W-1:0]     created_task,
	output logic [rrts_pkg::ID_W-1:0]     running_task,
	output logic [rrts_pkg::QLEN_W-1:0]   quantum_reload,
	output logic                          notify_valid,
	output logic [rrts_pkg::ID_W-1:0]     notify_pager,
	output logic [rrts_pkg::REASON_W-1:0] notify_reason
);

	rrts_pkg::cmd_t cmd;
	rrts_pkg::sts_t sts;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rrts_datapath u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.sts                    (sts),
		.quantum_length_wr_en   (quantum_length_wr_en),
		.quantum_length_wr_data (quantum_length_wr_data),
		.opcode                 (opcode),
		.target_task            (target_task),
		.pager_id               (pager_id),
		.exit_reason            (exit_reason),
		.status                 (status),
		.created_task           (created_task),
		.running_task           (running_task),
		.quantum_reload         (quantum_reload),
		.notify_valid           (notify_valid),
		.notify_pager           (notify_pager),
		.notify_reason          (notify_reason)
	);

endmodule

// File: src/rrts_checker.sv
// Port-level checker for the scheduler core and its bind.
module rrts_port_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    status,
	input logic [rrts_pkg::ID_W-1:0]     created_task,
	input logic [rrts_pkg::QLEN_W-1:0]   quantum_reload,
	input logic                          notify_valid
);

	// Keep a stalled result on offer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Go busy after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in flight");

	// Report a notification only on a successful exit
	a_notify_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && notify_valid |-> status == 3'(rrts_pkg::STAT_OK) && created_task == '0)
		else $error("notification on a failed or non-exit item");

	// Grant nothing on a failed item
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'(rrts_pkg::STAT_OK)
			|-> quantum_reload == '0 && created_task == '0 && !notify_valid)
		else $error("failed item carries a grant");

endmodule

bind round_robin_task_scheduler_core rrts_port_checker u_rrts_checker (.*);

// File: dv/rrts_checker.sv
// Scheduler checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 100ps
module rrts_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          quantum_length_wr_en,
	input  logic [rrts_pkg::QLEN_W-1:0]   quantum_length_wr_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic [rrts_pkg::ID_W-1:0]     target_task,
	input  logic [rrts_pkg::ID_W-1:0]     pager_id,
	input  logic [rrts_pkg::REASON_W-1:0] exit_reason,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [2:0]                    status,
	input  logic [rrts_pkg::ID_W-1:0]     created_task,
	input  logic [rrts_pkg::ID_W-1:0]     running_task,
	input  logic [rrts_pkg::QLEN_W-1:0]   quantum_reload,
	input  logic                          notify_valid,
	input  logic [rrts_pkg::ID_W-1:0]     notify_pager,
	input  logic [rrts_pkg::REASON_W-1:0] notify_reason,
	output int                            fail_count,
	output int                            pending
);

	localparam int NT = rrts_pkg::NUM_TASKS;
	localparam int IW = rrts_pkg::ID_W;

	typedef enum logic [1:0] {T_UNUSED, T_BLOCKED, T_RUNNABLE} tstate_t;

	typedef struct packed {
		logic [2:0]                    status;
		logic [IW-1:0]                 created;
		logic [IW-1:0]                 running;
		logic [rrts_pkg::QLEN_W-1:0]   quantum;
		logic                          nvalid;
		logic [IW-1:0]                 npager;
		logic [rrts_pkg::REASON_W-1:0] nreason;
	} sched_res_t;

	// Shadow copy of the scheduler state, indexed by task id
	tstate_t         tstate  [1:NT];
	logic [IW-1:0]   tpager  [1:NT];
	int              trefs   [1:NT];
	logic [IW-1:0]   nxt     [1:NT];
	logic [IW-1:0]   prv     [1:NT];
	bit              linked  [1:NT];
	logic [IW-1:0]   head, tail, cur;
	logic [rrts_pkg::QLEN_W-1:0] qlen;
	sched_res_t      expected_results[$];

	function automatic bit live(int t);
		return t >= 1 && t <= NT && tstate[t] != T_UNUSED;
	endfunction

	function automatic bit runnable(int t);
		return live(t) && tstate[t] == T_RUNNABLE;
	endfunction

	task automatic unlink(int t);
		int p, n;
		if (t < 1 || t > NT || !linked[t]) return;
		p = prv[t];
		n = nxt[t];
		if (p != 0) nxt[p] = IW'(n); else head = IW'(n);
		if (n != 0) prv[n] = IW'(p); else tail = IW'(p);
		linked[t] = 0;
		nxt[t] = '0;
		prv[t] = '0;
	endtask

	task automatic enqueue(int t);
		if (t < 1 || t > NT || linked[t]) return;
		prv[t] = tail;
		nxt[t] = '0;
		if (tail != 0) nxt[tail] = IW'(t); else head = IW'(t);
		tail = IW'(t);
		linked[t] = 1;
	endtask

	// Round-robin pick; returns the quantum granted
	task automatic reschedule(output logic [rrts_pkg::QLEN_W-1:0] q);
		int prev_t, next_t;
		prev_t = cur;
		if (head != 0) begin
			next_t = head;
			unlink(next_t);
		end else if (prev_t != 0 && runnable(prev_t)) begin
			next_t = prev_t;
		end else begin
			next_t = 0;
		end
		q = (next_t != 0) ? qlen : '0;
		if (next_t != prev_t) begin
			if (prev_t != 0 && runnable(prev_t)) enqueue(prev_t);
			cur = IW'(next_t);
		end
	endtask

	task automatic predict_op(input logic [2:0] op, input int tgt, input int pg,
			input logic [rrts_pkg::REASON_W-1:0] why);
		sched_res_t r;
		int tid, p;
		r = '0;
		case (op)
			rrts_pkg::OP_CREATE: begin
				tid = 0;
				for (int i = NT; i >= 1; i--)
					if (tstate[i] == T_UNUSED) tid = i;
				if (tid == 0) begin
					r.status = rrts_pkg::STAT_FULL;
				end else begin
					if (!live(pg)) pg = 0;
					tpager[tid] = IW'(pg);
					trefs[tid] = 0;
					if (pg != 0 && trefs[pg] < 127) trefs[pg]++;
					tstate[tid] = T_RUNNABLE;
					enqueue(tid);
					r.created = IW'(tid);
				end
			end
			rrts_pkg::OP_BLOCK: begin
				if (!runnable(tgt)) r.status = rrts_pkg::STAT_BAD;
				else begin
					tstate[tgt] = T_BLOCKED;
					unlink(tgt);
				end
			end
			rrts_pkg::OP_RESUME: begin
				if (!live(tgt) || tstate[tgt] != T_BLOCKED) r.status = rrts_pkg::STAT_BAD;
				else begin
					tstate[tgt] = T_RUNNABLE;
					enqueue(tgt);
				end
			end
			rrts_pkg::OP_SWITCH: reschedule(r.quantum);
			rrts_pkg::OP_DESTROY: begin
				if (!live(tgt) || tgt == cur) r.status = rrts_pkg::STAT_BAD;
				else if (tgt == rrts_pkg::PROT_ID) r.status = rrts_pkg::STAT_PROT;
				else if (trefs[tgt] > 0) r.status = rrts_pkg::STAT_REFD;
				else begin
					unlink(tgt);
					tstate[tgt] = T_UNUSED;
					p = tpager[tgt];
					if (p >= 1 && p <= NT && trefs[p] > 0) trefs[p]--;
					tpager[tgt] = '0;
				end
			end
			rrts_pkg::OP_EXIT: begin
				p = cur;
				if (p == 0 || !live(p)) r.status = rrts_pkg::STAT_BAD;
				else begin
					if (tpager[p] != 0) begin
						r.nvalid = 1;
						r.npager = tpager[p];
						r.nreason = why;
					end
					tstate[p] = T_BLOCKED;
					unlink(p);
					reschedule(r.quantum);
				end
			end
			default: r.status = rrts_pkg::STAT_BAD;
		endcase
		r.running = cur;
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_res_t e, a;
		if (!arst_n) begin
			for (int i = 1; i <= NT; i++) begin
				tstate[i] = T_UNUSED;
				tpager[i] = '0;
				trefs[i] = 0;
				nxt[i] = '0;
				prv[i] = '0;
				linked[i] = 0;
			end
			head = '0;
			tail = '0;
			cur = rrts_pkg::IDLE_ID;
			qlen = rrts_pkg::QLEN_RST;
			expected_results.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (quantum_length_wr_en) qlen = quantum_length_wr_data;
			// Compare an accepted result with the oldest expectation
			if (out_valid && !out_stall) begin
				a = '{status, created_task, running_task, quantum_reload,
					notify_valid, notify_pager, notify_reason};
				if (expected_results.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("%t: result with nothing expected: %h", $realtime, a);
				end else begin
					e = expected_results.pop_front();
					if (e !== a) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("%t: mismatch exp st=%0d cr=%0d run=%0d q=%0d nv=%0b np=%0d nr=%0d act st=%0d cr=%0d run=%0d q=%0d nv=%0b np=%0d nr=%0d",
								$realtime, e.status, e.created, e.running, e.quantum,
								e.nvalid, e.npager, e.nreason, a.status, a.created,
								a.running, a.quantum, a.nvalid, a.npager, a.nreason);
					end
				end
			end
			// Predict each accepted item
			if (in_valid && !in_stall)
				predict_op(opcode, target_task, pager_id, exit_reason);
			pending <= expected_results.size();
		end
	end

endmodule

// File: dv/tb_top.sv
// Testbench top: drives scheduler operations and quantum writes, and gives the verdict.
`timescale 1ns / 100ps
module tb_top;

	localparam int IW = rrts_pkg::ID_W;
	localparam int QW = rrts_pkg::QLEN_W;
	localparam int RSW = rrts_pkg::REASON_W;

	logic                clk;
	logic                arst_n;
	logic                quantum_length_wr_en;
	logic [QW-1:0]       quantum_length_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic [2:0]          opcode;
	logic [IW-1:0]       target_task;
	logic [IW-1:0]       pager_id;
	logic [RSW-1:0]      exit_reason;
	logic                out_valid;
	logic                out_stall;
	logic [2:0]          status;
	logic [IW-1:0]       created_task;
	logic [IW-1:0]       running_task;
	logic [QW-1:0]       quantum_reload;
	logic                notify_valid;
	logic [IW-1:0]       notify_pager;
	logic [RSW-1:0]      notify_reason;
	int                  fail_count;
	int                  pending;
	int                  send_idle_pct;
	int                  recv_idle_pct;

	round_robin_task_scheduler_core dut (.*);
	rrts_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("tb_top: errors");
		$finish;
	end

	// Receiver stall
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// Send one item and wait until it is accepted; valid drops only while idling
	task automatic send_op(logic [2:0] op, logic [IW-1:0] tgt, logic [IW-1:0] pg,
			logic [RSW-1:0] why);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		opcode <= op;
		target_task <= tgt;
		pager_id <= pg;
		exit_reason <= why;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_quantum(logic [QW-1:0] v);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		quantum_length_wr_en <= 1;
		quantum_length_wr_data <= v;
		@(posedge clk);
		quantum_length_wr_en <= 0;
	endtask

	// Random item, mostly well-formed ids on a busy task table
	task automatic random_op();
		int r;
		logic [2:0] op;
		logic [IW-1:0] tgt, pg;
		r = $urandom_range(99);
		if (r < 22) op = rrts_pkg::OP_CREATE;
		else if (r < 38) op = rrts_pkg::OP_BLOCK;
		else if (r < 54) op = rrts_pkg::OP_RESUME;
		else if (r < 74) op = rrts_pkg::OP_SWITCH;
		else if (r < 86) op = rrts_pkg::OP_DESTROY;
		else if (r < 97) op = rrts_pkg::OP_EXIT;
		else op = 3'($urandom_range(7));
		tgt = ($urandom_range(9) == 0) ? IW'($urandom_range(127))
			: IW'($urandom_range(16));
		pg = ($urandom_range(9) == 0) ? IW'($urandom_range(127))
			: IW'($urandom_range(12));
		send_op(op, tgt, pg, RSW'($urandom_range(255)));
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		opcode = '0;
		target_task = '0;
		pager_id = '0;
		exit_reason = '0;
		quantum_length_wr_en = 0;
		quantum_length_wr_data = '0;
		out_stall = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: edge ids, every operation, error cases
		send_op(rrts_pkg::OP_EXIT, 0, 0, 8'h00);
		send_op(rrts_pkg::OP_SWITCH, 0, 0, 0);
		send_op(rrts_pkg::OP_CREATE, 0, 0, 0);
		send_op(rrts_pkg::OP_CREATE, 0, 1, 0);
		send_op(rrts_pkg::OP_CREATE, 0, 2, 0);
		send_op(rrts_pkg::OP_CREATE, 0, 7'd127, 0);
		send_op(rrts_pkg::OP_CREATE, 0, 7'd64, 0);
		send_op(3'd6, 7'd127, 7'd127, 8'hff);
		send_op(3'd7, 0, 0, 0);
		send_op(rrts_pkg::OP_SWITCH, 0, 0, 0);
		send_op(rrts_pkg::OP_DESTROY, 1, 0, 0);
		send_op(rrts_pkg::OP_DESTROY, 2, 0, 0);
		send_op(rrts_pkg::OP_DESTROY, 3, 0, 0);
		send_op(rrts_pkg::OP_BLOCK, 2, 0, 0);
		send_op(rrts_pkg::OP_BLOCK, 2, 0, 0);
		send_op(rrts_pkg::OP_RESUME, 2, 0, 0);
		send_op(rrts_pkg::OP_RESUME, 2, 0, 0);
		send_op(rrts_pkg::OP_BLOCK, 0, 0, 0);
		send_op(rrts_pkg::OP_RESUME, 7'd64, 0, 0);
		send_op(rrts_pkg::OP_DESTROY, 7'd127, 0, 0);
		send_op(rrts_pkg::OP_EXIT, 0, 0, 8'hff);
		send_op(rrts_pkg::OP_SWITCH, 0, 0, 0);
		send_op(rrts_pkg::OP_EXIT, 0, 0, 8'h5a);
		send_op(rrts_pkg::OP_SWITCH, 0, 0, 0);
		// Fill the table past its size
		repeat (66) send_op(rrts_pkg::OP_CREATE, 0, IW'($urandom_range(64)), 0);
		write_quantum(16'hffff);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 73 : 0;
			recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 34 : 0;
			for (int i = 0; i < 550; i++) begin
				random_op();
				if (i == 275) write_quantum(ph == 0 ? 16'd1 : 16'($urandom_range(65535)));
			end
			write_quantum(ph == 1 ? 16'd0 : 16'($urandom_range(1, 65535)));
		end

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
